[hw/rtl/rlt_pkg.sv]
// Shared types and constants for the recursive lock table.
package rlt_pkg;

  localparam int ID_W         = 22;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int LOCK_COUNT_W = 16;

  typedef enum logic [KIND_W-1:0] {
    REQ_INIT   = 2'd0,
    REQ_LOCK   = 2'd1,
    REQ_UNLOCK = 2'd2,
    REQ_OTHER  = 2'd3
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_TABLE_FULL = 2'd1,
    STATUS_HELD       = 2'd2,
    STATUS_COUNT_ERR  = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } fsm_state_t;

  // Request broadcast to every cell.
  typedef struct packed {
    req_kind_t         kind;
    logic [ID_W-1:0]   group_id;
    logic [ID_W-1:0]   thread_id;
  } cell_req_t;

  // Per-cell answer; all zero unless the cell is the target.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [LOCK_COUNT_W-1:0] lock_count;
  } cell_rsp_t;

endpackage

[hw/rtl/rlt_if.sv]
// Valid/ready channel interfaces for lock requests and lock results.
interface rlt_req_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic [21:0]             group_id;
  logic [21:0]             thread_id;

  modport source (output valid, output req_type, output group_id, output thread_id,
                  input ready);
  modport sink   (input valid, input req_type, input group_id, input thread_id,
                  output ready);
endinterface

interface rlt_rsp_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [15:0]             lock_count;

  modport source (output valid, output status, output lock_count, input ready);
  modport sink   (input valid, input status, input lock_count, output ready);
endinterface

[hw/rtl/recursive_lock_table_unit.sv]
// Top level of the recursive lock table: request register, cell row, result register.
//
// Recursive lock table. Each request word names a process group and a thread;
// the group is looked up among the claimed entries, and on a miss the
// highest-numbered free entry is claimed with count zero. A lock succeeds when
// the count is zero or the thread already owns the lock, an unlock lowers the
// count, and a lock at the maximum count or an unlock at zero answers
// count_error with the count unchanged. When all NUM_ENTRIES entries are
// claimed, a request for a new group answers table_full with count zero.
// Entries are never freed. Every request yields one result word.
// Flow: a request word is first registered, and then every cell compares its
// group and the target cell updates itself. The next request is taken right
// after the result moves into the output register.
// If that register still holds an untaken result, the update waits for it.
// Reset clears the valid bits, the controller state and the result valid flag; no clearing pass runs.
module recursive_lock_table_unit #(
  parameter int NUM_ENTRIES = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  rlt_req_if.sink   req,
  rlt_rsp_if.source rsp
);
  import rlt_pkg::*;

  fsm_state_t state;
  fsm_state_t state_next;

  // Registered request, broadcast to all cells.
  cell_req_t  cur_req;

  // Result register.
  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic [LOCK_COUNT_W-1:0] out_count;

  logic                    exec_go;
  logic                    in_ready;

  logic [NUM_ENTRIES-1:0]  cell_valid;
  logic [NUM_ENTRIES-1:0]  cell_valid_up;
  logic [NUM_ENTRIES-1:0]  cell_match;
  logic [NUM_ENTRIES-1:0]  cell_target;
  cell_rsp_t               cell_rsp [NUM_ENTRIES];

  logic                    any_match;
  logic                    any_target;
  cell_rsp_t               merged;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the controller: take a word while idle, update once the
  // result register can take the answer.
  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EXEC: begin
        exec_go = !out_valid || rsp.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request word.
  always_ff @(posedge clk) begin
    if (in_ready && req.valid) begin
      cur_req.kind      <= req_kind_t'(req.req_type);
      cur_req.group_id  <= req.group_id;
      cur_req.thread_id <= req.thread_id;
    end
  end

  // Cell row. Each cell hands its valid bit to the neighbor below, which uses
  // it to tell whether it is the next free entry to claim.
  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    if (i == NUM_ENTRIES - 1) begin : g_top
      assign cell_valid_up[i] = 1'b1;
    end else begin : g_inner
      assign cell_valid_up[i] = cell_valid[i+1];
    end

    rlt_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .go        (exec_go),
      .req       (cur_req),
      .valid_up  (cell_valid_up[i]),
      .any_match (any_match),
      .valid     (cell_valid[i]),
      .match     (cell_match[i]),
      .target    (cell_target[i]),
      .rsp       (cell_rsp[i])
    );
  end

  assign any_match  = |cell_match;
  assign any_target = |cell_target;

  // At most one cell is the target and the others answer zero: merge by OR.
  always_comb begin
    merged = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      merged = merged | cell_rsp[i];
    end
  end

  // Result register: load on update, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      if (any_target) begin
        out_status <= merged.status;
        out_count  <= merged.lock_count;
      end else begin
        out_status <= STATUS_TABLE_FULL;
        out_count  <= '0;
      end
    end
  end

  assign req.ready      = in_ready;
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.lock_count = out_count;

  // Claimed entries always form a block at the top of the row.
  a_valid_thermo: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & ~cell_valid_up) == '0)
    else $error("claimed entries not contiguous from the top");

  // A group is claimed only on a miss, so it never sits in two entries.
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_match))
    else $error("group matched in more than one entry");

  a_target_unique: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> $onehot0(cell_target))
    else $error("more than one target entry");

  // An update always leaves a result waiting and returns to idle.
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> (out_valid && state == ST_IDLE))
    else $error("update did not produce a result");

  // A full table cannot have a free entry to offer.
  a_full_no_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && !any_target) |-> (&cell_valid))
    else $error("table_full answered with a free entry");

endmodule

[hw/rtl/rlt_cell.sv]
// One lock table entry: match, claim and lock/unlock update for its own slot.
module rlt_cell #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  rlt_pkg::cell_req_t req,
  input  logic              valid_up,
  input  logic              any_match,
  output logic              valid,
  output logic              match,
  output logic              target,
  output rlt_pkg::cell_rsp_t rsp
);
  import rlt_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [ID_W-1:0]       group;
  logic [ID_W-1:0]       owner;
  logic [COUNT_BITS-1:0] count;

  logic                  free_here;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  take_owner;
  status_t               status;

  always_comb begin
    match     = valid && (group == req.group_id);
    // Claimed entries fill from the top down, so the free slot to claim is
    // the one whose upper neighbor is already taken.
    free_here = !valid && valid_up;
    target    = match || (!any_match && free_here);
    cur_count = match ? count : '0;
  end

  always_comb begin
    count_next = cur_count;
    take_owner = 1'b0;
    status     = STATUS_OK;
    case (req.kind)
      REQ_LOCK: begin
        if ((cur_count == '0) || (owner == req.thread_id)) begin
          if (cur_count == CountMax) begin
            status = STATUS_COUNT_ERR;
          end else begin
            count_next = cur_count + COUNT_BITS'(1);
            take_owner = 1'b1;
          end
        end else begin
          status = STATUS_HELD;
        end
      end
      REQ_UNLOCK: begin
        if (cur_count == '0) begin
          status = STATUS_COUNT_ERR;
        end else begin
          count_next = cur_count - COUNT_BITS'(1);
        end
      end
      default: begin
        status = STATUS_OK;
      end
    endcase
  end

  always_comb begin
    rsp.status     = target ? status : STATUS_OK;
    rsp.lock_count = target ? LOCK_COUNT_W'(count_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (go && target) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go && target) begin
      group <= req.group_id;
      count <= count_next;
      if (take_owner) begin
        owner <= req.thread_id;
      end
    end
  end

endmodule

[verif/recursive_lock_table_unit_test.sv]
// Self-checking testbench for the recursive lock table unit.
module recursive_lock_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlt_pkg::*;

  // Match the block's default sizes; the predictor works at these widths.
  localparam int NUM_ENTRIES = 16;
  localparam int COUNT_BITS  = 16;
  localparam int RANDOM_WORDS = 300;
  localparam int CLIMB_DEPTH = 24;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    status_t                 status;
    logic [LOCK_COUNT_W-1:0] lock_count;
  } lock_result_t;

  logic clk;
  logic rst;

  rlt_req_if req ();
  rlt_rsp_if rsp ();

  recursive_lock_table_unit #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the lock table, advanced once per request word offered.
  logic                  shadow_valid [NUM_ENTRIES];
  logic [ID_W-1:0]       shadow_group [NUM_ENTRIES];
  logic [ID_W-1:0]       shadow_owner [NUM_ENTRIES];
  logic [COUNT_BITS-1:0] shadow_count [NUM_ENTRIES];

  lock_result_t    pending_results[$];  // predicted result words, oldest first
  logic [ID_W-1:0] claimed_groups[$];   // groups that own an entry

  // Knobs shared between the test tasks, the request sender and the result sink process.
  bit req_no_idle;
  bit rsp_no_idle;
  int rsp_hold_cycles;

  int mismatches;
  int words_sent;
  int words_checked;
  int full_seen;
  int held_seen;
  int count_err_seen;

  // Predict one request: look up the group, claim a free entry on a miss,
  // then apply the lock or unlock rules to that entry.
  task automatic predict_lock_request(input req_kind_t kind, input logic [ID_W-1:0] grp,
                                      input logic [ID_W-1:0] thr);
    int hit;
    int free_slot;
    lock_result_t res;
    hit = -1;
    free_slot = -1;
    res.status = STATUS_OK;
    res.lock_count = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (shadow_valid[i]) begin
        if (hit < 0 && shadow_group[i] == grp) hit = i;
      end else begin
        // Keep the highest free index.
        free_slot = i;
      end
    end
    if (hit < 0 && free_slot < 0) begin
      // Table full: no state changes, count reported as zero.
      res.status = STATUS_TABLE_FULL;
      full_seen++;
    end else begin
      if (hit < 0) begin
        hit = free_slot;
        shadow_valid[hit] = 1'b1;
        shadow_group[hit] = grp;
        shadow_count[hit] = '0;
        claimed_groups.push_back(grp);
      end
      case (kind)
        REQ_LOCK: begin
          if (shadow_count[hit] == '0 || shadow_owner[hit] == thr) begin
            if (shadow_count[hit] == '1) begin
              res.status = STATUS_COUNT_ERR;
            end else begin
              shadow_count[hit] = shadow_count[hit] + 1'b1;
              shadow_owner[hit] = thr;
            end
          end else begin
            res.status = STATUS_HELD;
          end
        end
        REQ_UNLOCK: begin
          // Any thread may unlock; only a zero count is refused.
          if (shadow_count[hit] == '0) res.status = STATUS_COUNT_ERR;
          else shadow_count[hit] = shadow_count[hit] - 1'b1;
        end
        default: ;
      endcase
      res.lock_count = shadow_count[hit][LOCK_COUNT_W-1:0];
      if (res.status == STATUS_HELD) held_seen++;
      if (res.status == STATUS_COUNT_ERR) count_err_seen++;
    end
    pending_results.push_back(res);
  endtask

  function automatic bit group_is_claimed(input logic [ID_W-1:0] grp);
    foreach (claimed_groups[i]) if (claimed_groups[i] == grp) return 1'b1;
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    else if (mismatches == MAX_REPORTS + 1)
      $display("%0t ns: further mismatches not shown", $time);
  endtask

  // Compare one accepted result word with the oldest prediction.
  task automatic check_lock_result(input logic [STATUS_W-1:0] st,
                                   input logic [LOCK_COUNT_W-1:0] cnt);
    lock_result_t want;
    words_checked++;
    if (pending_results.size() == 0) begin
      note_mismatch("unexpected result word, status", -1, st);
    end else begin
      want = pending_results.pop_front();
      if (st !== want.status) note_mismatch("status", want.status, st);
      if (cnt !== want.lock_count) note_mismatch("lock_count", want.lock_count, cnt);
    end
  endtask

  // Offer one request word after a random gap and hold it until it is taken.
  task automatic send_lock_request(input req_kind_t kind, input logic [ID_W-1:0] grp,
                                   input logic [ID_W-1:0] thr);
    int gap;
    gap = req_no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.req_type  <= kind;
    req.group_id  <= grp;
    req.thread_id <= thr;
    predict_lock_request(kind, grp, thr);
    do @(posedge clk); while (!req.ready);
    words_sent++;
  endtask

  // Drop valid and hold off until every predicted word has come back.
  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic req_kind_t random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return REQ_LOCK;
    if (r < 75) return REQ_UNLOCK;
    if (r < 88) return REQ_INIT;
    return REQ_OTHER;
  endfunction

  // Result sink: a random stall after each word, plus a long
  // hold-off when a test asks for one, counted here cycle by cycle.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        check_lock_result(rsp.status, rsp.lock_count);
        stall_left = rsp_no_idle ? 0 : $urandom_range(0, 4);
      end
      if (rsp_hold_cycles > 0) begin
        hold_left = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end
      if (rst) begin
        rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Walk one lock through claim, recursion, contention, unlock and the
  // unlock-at-zero error, with group and thread ids at their extremes.
  task automatic test_lock_basics();
    logic [ID_W-1:0] grp_lo;
    logic [ID_W-1:0] grp_hi;
    logic [ID_W-1:0] thr_a;
    logic [ID_W-1:0] thr_b;
    grp_lo = '0;
    grp_hi = '1;
    thr_a = '1;
    thr_b = '0;
    send_lock_request(REQ_INIT, grp_lo, 22'h2AAAAA);      // claim, count zero
    send_lock_request(REQ_LOCK, grp_lo, thr_a);           // first lock
    send_lock_request(REQ_LOCK, grp_lo, thr_a);           // recursive lock
    send_lock_request(REQ_LOCK, grp_lo, thr_b);           // held by the other thread
    send_lock_request(REQ_UNLOCK, grp_lo, thr_b);         // any thread may unlock
    send_lock_request(REQ_UNLOCK, grp_lo, thr_a);
    send_lock_request(REQ_UNLOCK, grp_lo, thr_a);         // unlock at zero
    send_lock_request(REQ_LOCK, grp_lo, thr_b);           // free again, new owner
    send_lock_request(REQ_OTHER, grp_lo, thr_a);          // lookup only
    send_lock_request(REQ_LOCK, grp_hi, 22'h155555);      // claim and lock at once
    send_lock_request(REQ_UNLOCK, 22'h2AAAAA, thr_a);     // claim, then unlock at zero
    send_lock_request(REQ_OTHER, 22'h155555, 22'h2AAAAA); // claim with a lookup only
    send_lock_request(REQ_INIT, grp_hi, thr_b);
    send_lock_request(REQ_LOCK, grp_hi, 22'h155555);
    send_lock_request(REQ_UNLOCK, grp_lo, 22'h2AAAAA);
  endtask

  // Drive one count deep into recursion back to back, let another thread
  // bounce off it, then unlock all the way down and once more at zero.
  task automatic test_count_climb();
    logic [ID_W-1:0] grp;
    logic [ID_W-1:0] owner;
    grp = 22'h123456;
    owner = 22'h0F0F0F;
    req_no_idle = 1'b1;
    rsp_no_idle = 1'b1;
    repeat (CLIMB_DEPTH) send_lock_request(REQ_LOCK, grp, owner);
    send_lock_request(REQ_LOCK, grp, 22'h303030);     // held, count deep
    repeat (CLIMB_DEPTH) send_lock_request(REQ_UNLOCK, grp, owner);
    send_lock_request(REQ_UNLOCK, grp, owner);        // unlock at zero
    send_lock_request(REQ_LOCK, grp, 22'h303030);     // free again, new owner
    req_no_idle = 1'b0;
    rsp_no_idle = 1'b0;
  endtask

  // Stall the result side for a long stretch while requests keep coming,
  // then pause the sender until the block has emptied.
  task automatic test_backpressure();
    logic [ID_W-1:0] grp;
    rsp_hold_cycles = 60;
    req_no_idle = 1'b1;
    repeat (12) begin
      grp = claimed_groups[$urandom_range(0, claimed_groups.size() - 1)];
      send_lock_request(random_kind(), grp, 22'($urandom_range(0, 2)));
    end
    req_no_idle = 1'b0;
    drain_results();
    repeat (6) begin
      grp = claimed_groups[$urandom_range(0, claimed_groups.size() - 1)];
      send_lock_request(random_kind(), grp, 22'($urandom_range(0, 2)));
    end
  endtask

  // Mostly known groups with a small thread pool so that ownership,
  // recursion and contention come up often; new groups fill the table.
  task automatic test_random_traffic();
    logic [ID_W-1:0] thread_pool[3];
    logic [ID_W-1:0] grp;
    logic [ID_W-1:0] thr;
    int n;
    foreach (thread_pool[i]) thread_pool[i] = 22'($urandom);
    for (n = 0; n < RANDOM_WORDS; n++) begin
      // Switch idle behavior in stretches, some of them without any gaps.
      if (n % 50 == 0) begin
        req_no_idle = ($urandom_range(0, 3) == 0);
        rsp_no_idle = ($urandom_range(0, 3) == 0);
      end
      if (claimed_groups.size() == 0 || $urandom_range(0, 99) < 20)
        grp = 22'($urandom);
      else
        grp = claimed_groups[$urandom_range(0, claimed_groups.size() - 1)];
      if ($urandom_range(0, 9) < 7) thr = thread_pool[$urandom_range(0, 2)];
      else thr = 22'($urandom);
      send_lock_request(random_kind(), grp, thr);
    end
    req_no_idle = 1'b0;
    rsp_no_idle = 1'b0;
  endtask

  // Claim whatever entries are left, then send every kind for a new group.
  task automatic test_table_full();
    logic [ID_W-1:0] grp;
    while (claimed_groups.size() < NUM_ENTRIES) begin
      do grp = 22'($urandom); while (group_is_claimed(grp));
      send_lock_request(REQ_INIT, grp, 22'($urandom));
    end
    for (int k = 0; k < 4; k++) begin
      do grp = 22'($urandom); while (group_is_claimed(grp));
      send_lock_request(req_kind_t'(k), grp, 22'($urandom));
    end
    // Claimed groups keep working while the table is full.
    send_lock_request(REQ_LOCK, claimed_groups[0], 22'h0);
    send_lock_request(REQ_UNLOCK, claimed_groups[0], 22'h0);
  endtask

  // Give up if the run hangs.
  initial begin
    #2_000_000;
    $display("FAIL recursive_lock_table_unit");
    $finish;
  end

  initial begin
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    req_no_idle = 1'b0;
    rsp_no_idle = 1'b0;
    rsp_hold_cycles = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    full_seen = 0;
    held_seen = 0;
    count_err_seen = 0;
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.req_type  <= REQ_INIT;
    req.group_id  <= '0;
    req.thread_id <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_lock_basics();
    test_count_climb();
    test_backpressure();
    test_random_traffic();
    test_table_full();

    // Let any stray word surface before the verdict.
    drain_results();
    repeat (10) @(posedge clk);

    $display("Ran %0d request words through %0d table entries, %0d results checked;",
             words_sent, NUM_ENTRIES, words_checked);
    $display("saw %0d table_full, %0d held_by_other and %0d count_error answers.",
             full_seen, held_seen, count_err_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS recursive_lock_table_unit");
    end else begin
      $display("FAIL recursive_lock_table_unit");
    end
    $finish;
  end

endmodule
